// ===== src/chfm_pkg.sv =====
package chfm_pkg;

    // Default sample width and CORDIC depth.
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fraction bits added below the sample before the rotations.
    localparam int GUARD_BITS = 8;

    // Angle accumulator, 2^-16 degree per LSB.
    // Its worst case is 180 degrees plus the sum of all micro-rotation angles.
    localparam int ZW = 26;

    // Heading arithmetic width and the output width, both in 1/64 degree.
    localparam int HW = 18;
    localparam int OW = 15;

    localparam int ATAN_LEN = 24;

    localparam logic signed [ZW-1:0] ANG_HALF_TURN = ZW'(11796480);
    localparam logic signed [ZW-1:0] ROUND_HALF    = ZW'(512);
    localparam int                   ROUND_SHIFT   = 10;

    localparam logic signed [HW-1:0] HALF_TURN = HW'(11520);
    localparam logic signed [HW-1:0] FULL_TURN = HW'(23040);

    // -8.58 degrees in 1/64 degree units.
    localparam logic signed [OW-1:0] DECL_RESET = OW'(-549);

    // Handshake state that travels with the input stage and every rotation stage.
    typedef struct packed {
        logic valid;
        logic hold;   // angle is already final, the rotations leave it alone
    } t_stage_ctl;

    // atan(2^-idx) in units of 2^-16 degree.
    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/chfm_sample_if.sv =====
interface chfm_sample_if #(
    parameter int SAMPLE_BITS = chfm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] raw_x;
    logic signed [SAMPLE_BITS-1:0] raw_y;

    modport source (output valid, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

// ===== src/chfm_heading_if.sv =====
interface chfm_heading_if;
    logic                              valid;
    logic                              ready;
    logic signed [chfm_pkg::OW-1:0]    heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

// ===== src/chfm_cordic_stage.sv =====
module chfm_cordic_stage #(
    parameter int IDX = 0,
    parameter int W   = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chfm_pkg::t_stage_ctl          i_ctl,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic signed [chfm_pkg::ZW-1:0] i_z,
    output logic                          o_ready,
    input  logic                          i_ready,
    output chfm_pkg::t_stage_ctl          o_ctl,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [chfm_pkg::ZW-1:0] o_z
);
    import chfm_pkg::*;

    t_stage_ctl           r_ctl;
    logic signed [W-1:0]  r_x;
    logic signed [W-1:0]  r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [W-1:0]  n_x;
    logic signed [W-1:0]  n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [W-1:0]  dx;
    logic signed [W-1:0]  dy;
    logic signed [ZW-1:0] ang;

    assign o_ready = !r_ctl.valid || i_ready;

    // One vectoring micro-rotation: drive y toward zero.
    always_comb begin
        dx  = i_y >>> IDX;
        dy  = i_x >>> IDX;
        ang = atan_deg(5'(IDX));
        if (i_ctl.hold) begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end else if (!i_y[W-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ang;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== src/compass_heading_from_magnetometer_unit.sv =====
// Compass heading from one raw magnetometer sample.
//
// Input channel i_sample carries raw_x and raw_y, two's complement samples of
// SAMPLE_BITS bits. Output channel o_heading carries one heading per sample,
// signed 1/64-degree units in -180..+180 degrees, after the declination held
// in the configuration register has been subtracted. The register is written
// through i_cfg_we / i_cfg_wdata and should only change while the pipeline
// is empty.
//
// The datapath is one input stage, CORDIC_STAGES rotation stages and one
// output stage, each registered. Every stage holds one sample, so a new
// sample can be taken on every cycle while the output is not stalled, and the
// sustained rate without a stall is one sample per cycle; the pipeline depth
// sets the latency.
//
// Each stage moves forward when it is empty or its successor moves, so a
// stall at the output fills the empty stages first and then holds every
// stage in place; no sample is dropped or repeated. Reset empties all stages
// and loads the declination with -8.58 degrees.
module compass_heading_from_magnetometer_unit #(
    parameter int CORDIC_STAGES = chfm_pkg::CORDIC_STAGES_DEF,
    parameter int SAMPLE_BITS   = chfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    chfm_sample_if.sink               i_sample,
    chfm_heading_if.source            o_heading,
    input  logic                      i_cfg_we,
    input  logic [chfm_pkg::OW-1:0]   i_cfg_wdata
);
    import chfm_pkg::*;

    // Rotation datapath width: sample, sign, guard fraction and CORDIC gain.
    localparam int W  = SAMPLE_BITS + GUARD_BITS + 4;
    localparam int NW = SAMPLE_BITS + 1;

    // Declination register.
    logic signed [OW-1:0] r_decl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= DECL_RESET;
        end else if (i_cfg_we) begin
            r_decl <= i_cfg_wdata;
        end
    end

    // Stage chain signals; index 0 is the input stage output.
    t_stage_ctl           s_ctl [0:CORDIC_STAGES];
    logic signed [W-1:0]  s_x   [0:CORDIC_STAGES];
    logic signed [W-1:0]  s_y   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] s_z   [0:CORDIC_STAGES];
    logic                 s_rdy [0:CORDIC_STAGES];

    // Input stage: negate both axes one bit wider than the sample, turn the
    // vector into the right half plane and preload the angle.
    t_stage_ctl           r_in_ctl;
    logic signed [W-1:0]  r_in_x;
    logic signed [W-1:0]  r_in_y;
    logic signed [ZW-1:0] r_in_z;

    logic                 in_adv;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] cx;
    logic signed [NW-1:0] cy;
    logic                 ny_zero;
    logic                 ny_neg;
    logic                 nx_neg;
    logic signed [ZW-1:0] n_in_z;

    assign in_adv         = !r_in_ctl.valid || s_rdy[0];
    assign i_sample.ready = in_adv;

    always_comb begin
        nx      = -{i_sample.raw_x[SAMPLE_BITS-1], i_sample.raw_x};
        ny      = -{i_sample.raw_y[SAMPLE_BITS-1], i_sample.raw_y};
        ny_zero = (ny == '0);
        ny_neg  = ny[NW-1];
        nx_neg  = nx[NW-1];
        cx      = ny_neg ? -ny : ny;
        cy      = ny_neg ? -nx : nx;
        if (ny_zero) begin
            // Straight along the X axis: 180 degrees or 0, no rotations.
            n_in_z = nx_neg ? ANG_HALF_TURN : '0;
        end else if (ny_neg) begin
            n_in_z = nx_neg ? -ANG_HALF_TURN : ANG_HALF_TURN;
        end else begin
            n_in_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (in_adv) begin
            r_in_ctl.valid <= i_sample.valid;
            r_in_ctl.hold  <= ny_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_sample.valid) begin
            r_in_x <= W'(cx) <<< GUARD_BITS;
            r_in_y <= W'(cy) <<< GUARD_BITS;
            r_in_z <= n_in_z;
        end
    end

    assign s_ctl[0] = r_in_ctl;
    assign s_x[0]   = r_in_x;
    assign s_y[0]   = r_in_y;
    assign s_z[0]   = r_in_z;

    // Rotation stages, one micro-rotation each.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
        chfm_cordic_stage #(
            .IDX (k),
            .W   (W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[k]),
            .i_x     (s_x[k]),
            .i_y     (s_y[k]),
            .i_z     (s_z[k]),
            .o_ready (s_rdy[k]),
            .i_ready (s_rdy[k+1]),
            .o_ctl   (s_ctl[k+1]),
            .o_x     (s_x[k+1]),
            .o_y     (s_y[k+1]),
            .o_z     (s_z[k+1])
        );
    end

    // Output stage: round the angle to 1/64 degree, subtract the declination
    // and wrap once into -180..+180 degrees.
    logic                 r_out_valid;
    logic signed [OW-1:0] r_heading;

    logic                 out_adv;
    logic signed [ZW-1:0] z_rnd;
    logic signed [HW-1:0] ang_q;
    logic signed [HW-1:0] diff;
    logic signed [HW-1:0] n_heading;

    assign out_adv                = !r_out_valid || o_heading.ready;
    assign s_rdy[CORDIC_STAGES]   = out_adv;

    always_comb begin
        z_rnd = (s_z[CORDIC_STAGES] + ROUND_HALF) >>> ROUND_SHIFT;
        ang_q = z_rnd[HW-1:0];
        diff  = ang_q - HW'(r_decl);
        if (diff > HALF_TURN) begin
            n_heading = diff - FULL_TURN;
        end else if (diff < -HALF_TURN) begin
            n_heading = diff + FULL_TURN;
        end else begin
            n_heading = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= s_ctl[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && s_ctl[CORDIC_STAGES].valid) begin
            r_heading <= n_heading[OW-1:0];
        end
    end

    assign o_heading.valid   = r_out_valid;
    assign o_heading.heading = r_heading;

endmodule
